[design/text_terminal_writer_top_defines.svh]
// Assertion macros for the terminal writer checker.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef TEXT_TERMINAL_WRITER_TOP_DEFINES_SVH
`define TEXT_TERMINAL_WRITER_TOP_DEFINES_SVH

// Condition holds at every edge.
`define TTW_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TTW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/ttw_pkg.sv]
package ttw_pkg;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] char_code;
      logic [4:0] row_sel;
      logic [6:0] col_sel;
      logic [7:0] attr_in;
      logic [6:0] lines_back;
   } req_type;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic [10:0] cursor_linear;
      logic [7:0]  read_char;
      logic [7:0]  read_attr;
      logic        read_valid;
      logic [7:0]  history_count;
   } rsp_type;

   localparam logic [2:0] MODE_PUT       = 3'd0;
   localparam logic [2:0] MODE_SET_CUR   = 3'd1;
   localparam logic [2:0] MODE_SET_COLOR = 3'd2;
   localparam logic [2:0] MODE_CLEAR     = 3'd3;
   localparam logic [2:0] MODE_WRITE     = 3'd4;
   localparam logic [2:0] MODE_READ      = 3'd5;
   localparam logic [2:0] MODE_HIST      = 3'd6;

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_SPACE     = 8'd32;
   localparam logic [7:0] RESET_COLOR  = 8'd10;

   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_ENABLE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_COLOR = 4'd1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SAVE,
      ST_SHIFT,
      ST_CLEAR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic save;
      logic commit;
      logic shift;
      logic clear;
      logic init;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic need_scroll;
      logic need_clear;
      logic last_col;
      logic last_cell;
   } status_type;

endpackage

[design/ttw_ram.sv]
module ttw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[design/ttw_ctrl.sv]
module ttw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                rsp_free,
   input  ttw_pkg::status_type status,
   output ttw_pkg::cmd_type    cmd,
   output logic                req_stall
);
   import ttw_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.last_cell) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.need_scroll) state_in = ST_SAVE;
            else if (status.need_clear) state_in = ST_CLEAR;
            else state_in = ST_FINISH;
         end
         ST_SAVE: begin
            if (status.last_col) state_in = ST_SHIFT;
         end
         ST_SHIFT, ST_CLEAR: begin
            if (status.last_cell) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = req_valid ? ST_EXEC : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_INIT: begin
            cmd.init = 1'b1;
            cmd.step = !status.last_cell;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_EXEC: cmd.exec = 1'b1;
         ST_SAVE: begin
            cmd.save   = 1'b1;
            cmd.commit = status.last_col;
            cmd.step   = !status.last_col;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            cmd.step  = !status.last_cell;
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.step  = !status.last_cell;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.finish = 1'b1;
               req_stall  = 1'b0;
               cmd.load   = req_valid;
            end
         end
         default: ;
      endcase
   end
endmodule

[design/ttw_dp.sv]
module ttw_dp #(
   parameter int COLUMNS       = 80,
   parameter int ROWS          = 25,
   parameter int HISTORY_LINES = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  ttw_pkg::cmd_type    cmd,
   output ttw_pkg::status_type status,
   input  ttw_pkg::req_type    req_data,
   input  logic                scroll_enable,
   input  logic [7:0]          base_color,
   output ttw_pkg::rsp_type    result
);
   import ttw_pkg::*;

   localparam int CELLS      = ROWS * COLUMNS;
   localparam int SCR_AW     = $clog2(CELLS);
   localparam int HIST_CELLS = HISTORY_LINES * COLUMNS;
   localparam int HIST_AW    = $clog2(HIST_CELLS);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int HEAD_W     = $clog2(HISTORY_LINES);
   localparam int FILL_W     = $clog2(HISTORY_LINES + 1);

   req_type             req_ff, req_in;
   logic [ROW_W-1:0]    cur_row_ff, cur_row_in;
   logic [COL_W-1:0]    cur_col_ff, cur_col_in;
   logic [7:0]          cur_attr_ff, cur_attr_in;
   logic [HEAD_W-1:0]   head_ff, head_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SCR_AW-1:0]   idx_ff, idx_in;
   logic                sw_en_ff, sw_en_in;
   logic [SCR_AW-1:0]   sw_addr_ff, sw_addr_in;
   logic                sw_blank_ff, sw_blank_in;
   logic                hw_en_ff, hw_en_in;
   logic [HIST_AW-1:0]  hw_addr_ff, hw_addr_in;

   logic                s_we;
   logic [SCR_AW-1:0]   s_waddr, s_raddr;
   logic [15:0]         s_wdata, s_rdata;
   logic [HIST_AW-1:0]  h_raddr;
   logic [7:0]          h_rdata;

   logic                in_screen, is_put, is_nl, is_bs, at_last_col, at_last_row;
   logic                advance_row, hist_ok;
   logic [SCR_AW-1:0]   cell_addr, cur_addr;
   int                  line_raw;
   logic [HEAD_W-1:0]   line;

   assign in_screen   = (32'(req_ff.row_sel) < ROWS) && (32'(req_ff.col_sel) < COLUMNS);
   assign cell_addr   = in_screen ?
                        SCR_AW'(32'(req_ff.row_sel) * COLUMNS + 32'(req_ff.col_sel)) : '0;
   assign cur_addr    = SCR_AW'(32'(cur_row_ff) * COLUMNS + 32'(cur_col_ff));
   assign is_put      = req_ff.mode == MODE_PUT;
   assign is_nl       = req_ff.char_code == CH_NEWLINE;
   assign is_bs       = req_ff.char_code == CH_BACKSPACE;
   assign at_last_col = 32'(cur_col_ff) == COLUMNS - 1;
   assign at_last_row = 32'(cur_row_ff) == ROWS - 1;
   assign advance_row = is_put && (is_nl || (!is_bs && at_last_col));

   assign status.need_scroll = advance_row && at_last_row && scroll_enable;
   assign status.need_clear  = req_ff.mode == MODE_CLEAR;
   assign status.last_col    = 32'(idx_ff) == COLUMNS - 1;
   assign status.last_cell   = 32'(idx_ff) == CELLS - 1;

   // History line: newest saved line sits just behind the head.
   assign hist_ok  = (32'(req_ff.lines_back) < 32'(fill_ff)) && (32'(req_ff.col_sel) < COLUMNS);
   assign line_raw = 32'(head_ff) + HISTORY_LINES - 1 - 32'(req_ff.lines_back);
   assign line     = (line_raw >= HISTORY_LINES) ? HEAD_W'(line_raw - HISTORY_LINES)
                                                 : HEAD_W'(line_raw);
   assign h_raddr  = hist_ok ? HIST_AW'(32'(line) * COLUMNS + 32'(req_ff.col_sel)) : '0;

   always_comb begin
      req_in      = cmd.load ? req_data : req_ff;
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      cur_attr_in = cur_attr_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      if (cmd.exec) begin
         case (req_ff.mode)
            MODE_PUT: begin
               if (advance_row) begin
                  cur_col_in = '0;
                  if (!at_last_row) cur_row_in = cur_row_ff + 1'b1;
                  else if (!scroll_enable) cur_row_in = '0;
               end else if (is_bs) begin
                  if (cur_col_ff != '0) begin
                     cur_col_in = cur_col_ff - 1'b1;
                  end else if (cur_row_ff != '0) begin
                     cur_row_in = cur_row_ff - 1'b1;
                     cur_col_in = COL_W'(COLUMNS - 1);
                  end
               end else begin
                  cur_col_in = cur_col_ff + 1'b1;
               end
            end
            MODE_SET_CUR: begin
               cur_row_in = (32'(req_ff.row_sel) < ROWS) ? ROW_W'(req_ff.row_sel)
                                                         : ROW_W'(ROWS - 1);
               cur_col_in = (32'(req_ff.col_sel) < COLUMNS) ? COL_W'(req_ff.col_sel)
                                                            : COL_W'(COLUMNS - 1);
            end
            MODE_SET_COLOR: cur_attr_in = req_ff.attr_in;
            MODE_CLEAR: begin
               cur_row_in  = '0;
               cur_col_in  = '0;
               cur_attr_in = base_color;
            end
            default: ;
         endcase
      end
      if (cmd.commit) begin
         cur_attr_in = base_color;
         head_in     = (32'(head_ff) == HISTORY_LINES - 1) ? '0 : head_ff + 1'b1;
         if (32'(fill_ff) < HISTORY_LINES) fill_in = fill_ff + 1'b1;
      end
   end

   always_comb begin
      idx_in      = cmd.step ? idx_ff + 1'b1 : '0;
      sw_en_in    = cmd.shift;
      sw_addr_in  = idx_ff;
      sw_blank_in = 32'(idx_ff) >= CELLS - COLUMNS;
      hw_en_in    = cmd.save;
      hw_addr_in  = HIST_AW'(32'(head_ff) * COLUMNS + 32'(idx_ff));
   end

   // Screen port: delayed scroll writes first, then item writes, then sweeps.
   always_comb begin
      s_we    = 1'b0;
      s_waddr = cur_addr;
      s_wdata = {cur_attr_ff, req_ff.char_code};
      if (sw_en_ff) begin
         s_we    = 1'b1;
         s_waddr = sw_addr_ff;
         s_wdata = sw_blank_ff ? {base_color, CH_SPACE} : s_rdata;
      end else if (cmd.exec && is_put && !is_nl && !is_bs) begin
         s_we = 1'b1;
      end else if (cmd.exec && req_ff.mode == MODE_WRITE && in_screen) begin
         s_we    = 1'b1;
         s_waddr = cell_addr;
      end else if (cmd.clear) begin
         s_we    = 1'b1;
         s_waddr = idx_ff;
         s_wdata = {base_color, CH_SPACE};
      end else if (cmd.init) begin
         s_we    = 1'b1;
         s_waddr = idx_ff;
         s_wdata = {RESET_COLOR, CH_SPACE};
      end
   end

   always_comb begin
      if (cmd.save) s_raddr = idx_ff;
      else if (cmd.shift && (32'(idx_ff) < CELLS - COLUMNS))
         s_raddr = SCR_AW'(32'(idx_ff) + COLUMNS);
      else s_raddr = cell_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff  <= '0;
         cur_col_ff  <= '0;
         cur_attr_ff <= RESET_COLOR;
         head_ff     <= '0;
         fill_ff     <= '0;
         idx_ff      <= '0;
         sw_en_ff    <= 1'b0;
         hw_en_ff    <= 1'b0;
      end else begin
         cur_row_ff  <= cur_row_in;
         cur_col_ff  <= cur_col_in;
         cur_attr_ff <= cur_attr_in;
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         idx_ff      <= idx_in;
         sw_en_ff    <= sw_en_in;
         hw_en_ff    <= hw_en_in;
      end
      req_ff      <= req_in;
      sw_addr_ff  <= sw_addr_in;
      sw_blank_ff <= sw_blank_in;
      hw_addr_ff  <= hw_addr_in;
   end

   ttw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_screen (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   ttw_ram #(.WIDTH(8), .DEPTH(HIST_CELLS)) u_history (
      .clock (clock),
      .we    (hw_en_ff),
      .waddr (hw_addr_ff),
      .wdata (s_rdata[7:0]),
      .raddr (h_raddr),
      .rdata (h_rdata)
   );

   always_comb begin
      result               = '0;
      result.cursor_row    = 5'(cur_row_ff);
      result.cursor_col    = 7'(cur_col_ff);
      result.cursor_linear = 11'(32'(cur_row_ff) * COLUMNS + 32'(cur_col_ff));
      result.history_count = 8'(fill_ff);
      case (req_ff.mode)
         MODE_READ: begin
            if (in_screen) begin
               result.read_char  = s_rdata[7:0];
               result.read_attr  = s_rdata[15:8];
               result.read_valid = 1'b1;
            end
         end
         MODE_HIST: begin
            if (hist_ok) begin
               result.read_char  = h_rdata;
               result.read_valid = 1'b1;
            end
         end
         default: ;
      endcase
   end
endmodule

[design/text_terminal_writer_top.sv]
// An accepted transaction goes through EXEC, then FINISH, which loads the result into
// the output register once that is free and may accept the next transaction. A clear
// adds a sweep over all ROWS*COLUMNS cells, a scroll a save of the top row and a shift
// of all cells. Reset (synchronous, active high) starts a pass that blanks the screen;
// req_stall stays high through it while configuration writes are taken.
module text_terminal_writer_top #(
   parameter int COLUMNS       = 80,
   parameter int ROWS          = 25,
   parameter int HISTORY_LINES = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ttw_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ttw_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ttw_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [7:0]                           csr_data
);
   import ttw_pkg::*;

   // Configuration registers: user writes only while terminal is idle, unenforced.
   logic       scroll_en_ff, scroll_en_in;
   logic [7:0] def_color_ff, def_color_in;

   // Output register: parts the result side from the engine so a new
   // transaction can be accepted while the previous result waits.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   cmd_type    cmd;
   status_type status;
   rsp_type    result;
   logic       rsp_free;

   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      scroll_en_in = scroll_en_ff;
      def_color_in = def_color_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SCROLL_ENABLE: scroll_en_in = csr_data[0];
            CSR_DEFAULT_COLOR: def_color_in = csr_data;
            default: ;   // drop writes to unknown registers
         endcase
      end
   end

   always_comb begin
      // Drop the result once taken; load a fresh one when the engine finishes.
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_en_ff <= 1'b1;
         def_color_ff <= RESET_COLOR;
         rsp_valid_ff <= 1'b0;
      end else begin
         scroll_en_ff <= scroll_en_in;
         def_color_ff <= def_color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer: decides per transaction which sweeps run.
   ttw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_free  (rsp_free),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // Datapath: cursor, history ring pointers, screen and history RAMs.
   ttw_dp #(
      .COLUMNS       (COLUMNS),
      .ROWS          (ROWS),
      .HISTORY_LINES (HISTORY_LINES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_data      (req_data),
      .scroll_enable (scroll_en_ff),
      .base_color    (def_color_ff),
      .result        (result)
   );
endmodule

[design/ttw_checker.sv]
`include "text_terminal_writer_top_defines.svh"

module ttw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ttw_pkg::rsp_type rsp_data
);
   import ttw_pkg::*;

`TTW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
`TTW_ASSERT_ALWAYS(a_cursor_range, !rsp_valid || (32'(rsp_data.cursor_row) < ROWS && 32'(rsp_data.cursor_col) < COLUMNS), "cursor out of screen")
`TTW_ASSERT_ALWAYS(a_cursor_linear, !rsp_valid || rsp_data.cursor_linear == 11'(32'(rsp_data.cursor_row) * COLUMNS + 32'(rsp_data.cursor_col)), "linear cursor mismatch")
`TTW_ASSERT_ALWAYS(a_read_zero, !rsp_valid || rsp_data.read_valid || (rsp_data.read_char == 8'd0 && rsp_data.read_attr == 8'd0), "read data without valid")
endmodule

bind text_terminal_writer_top ttw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_ttw_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[test/text_terminal_writer_top_test.sv]
module text_terminal_writer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ttw_pkg::*;

   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int HISTORY_LINES = 128;
   localparam int CELLS         = ROWS * COLUMNS;
   // mode seven has no package name; it is a no-op for the block
   localparam logic [2:0] MODE_NOP = 3'd7;
   // the limit must outlast a scroll's save and shift sweeps and the long receiver hold
   localparam int STALL_LIMIT   = 30000;
   localparam int HOLD_CYCLES   = 400;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 4'd9;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0] csr_data;

   text_terminal_writer_top #(
      .COLUMNS(COLUMNS), .ROWS(ROWS), .HISTORY_LINES(HISTORY_LINES)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // terminal mirror: screen, scrollback ring, cursor and registers
   logic [15:0] screen_mirror [0:CELLS-1];
   logic [7:0]  ring_mirror [0:HISTORY_LINES*COLUMNS-1];
   int          ring_head;
   int          ring_fill;
   int          row_now;
   int          col_now;
   logic [7:0]  attr_now;
   logic        scroll_on;
   logic [7:0]  color_default;

   req_type     pending_cmds[$];
   rsp_type     expected_status[$];

   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_ticket;
   int          hold_seen;
   int          hold_left;
   int          mismatches;
   int          quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // terminal mirror
   // ---------------------------------------------------------------------
   task automatic mirror_blank();
      for (int i = 0; i < CELLS; i++) screen_mirror[i] = {color_default, CH_SPACE};
   endtask

   // advance to the next row; scroll or wrap at the bottom
   task automatic mirror_next_row();
      row_now++;
      if (row_now < ROWS) return;
      if (scroll_on) begin
         for (int c = 0; c < COLUMNS; c++)
            ring_mirror[ring_head*COLUMNS + c] = screen_mirror[c][7:0];
         ring_head = (ring_head + 1) % HISTORY_LINES;
         if (ring_fill < HISTORY_LINES) ring_fill++;
         attr_now = color_default;
         for (int i = 0; i < (ROWS-1)*COLUMNS; i++) screen_mirror[i] = screen_mirror[i+COLUMNS];
         for (int c = 0; c < COLUMNS; c++)
            screen_mirror[(ROWS-1)*COLUMNS + c] = {color_default, CH_SPACE};
         row_now = ROWS - 1;
         col_now = 0;
      end else begin
         row_now = 0;
      end
   endtask

   task automatic mirror_apply(input req_type cmd, output rsp_type status);
      logic [7:0] rd_char;
      logic [7:0] rd_attr;
      logic       rd_ok;
      logic       on_screen;
      int         line;
      rd_char   = '0;
      rd_attr   = '0;
      rd_ok     = 1'b0;
      on_screen = cmd.row_sel < ROWS && cmd.col_sel < COLUMNS;
      case (cmd.mode)
         MODE_PUT: begin
            if (cmd.char_code == CH_NEWLINE) begin
               mirror_next_row();
               col_now = 0;
            end else if (cmd.char_code == CH_BACKSPACE) begin
               if (col_now > 0) col_now--;
               else if (row_now > 0) begin
                  row_now--;
                  col_now = COLUMNS - 1;
               end
            end else begin
               screen_mirror[row_now*COLUMNS + col_now] = {attr_now, cmd.char_code};
               col_now++;
               if (col_now >= COLUMNS) begin
                  col_now = 0;
                  mirror_next_row();
               end
            end
         end
         MODE_SET_CUR: begin
            row_now = cmd.row_sel < ROWS ? int'(cmd.row_sel) : ROWS - 1;
            col_now = cmd.col_sel < COLUMNS ? int'(cmd.col_sel) : COLUMNS - 1;
         end
         MODE_SET_COLOR: attr_now = cmd.attr_in;
         MODE_CLEAR: begin
            row_now  = 0;
            col_now  = 0;
            attr_now = color_default;
            mirror_blank();
         end
         MODE_WRITE: begin
            if (on_screen)
               screen_mirror[cmd.row_sel*COLUMNS + cmd.col_sel] = {attr_now, cmd.char_code};
         end
         MODE_READ: begin
            if (on_screen) begin
               {rd_attr, rd_char} = screen_mirror[cmd.row_sel*COLUMNS + cmd.col_sel];
               rd_ok = 1'b1;
            end
         end
         MODE_HIST: begin
            if (cmd.lines_back < ring_fill && cmd.col_sel < COLUMNS) begin
               line    = (ring_head + HISTORY_LINES - 1 - cmd.lines_back) % HISTORY_LINES;
               rd_char = ring_mirror[line*COLUMNS + cmd.col_sel];
               rd_ok   = 1'b1;
            end
         end
         default: ;
      endcase
      status.cursor_row    = row_now[4:0];
      status.cursor_col    = col_now[6:0];
      status.cursor_linear = 11'(row_now*COLUMNS + col_now);
      status.read_char     = rd_char;
      status.read_attr     = rd_attr;
      status.read_valid    = rd_ok;
      status.history_count = ring_fill[7:0];
   endtask

   // ---------------------------------------------------------------------
   // command builders
   // ---------------------------------------------------------------------
   function automatic req_type make_cmd(logic [2:0] mode, logic [7:0] ch,
                                        logic [4:0] row, logic [6:0] col);
      req_type cmd;
      cmd.mode       = mode;
      cmd.char_code  = ch;
      cmd.row_sel    = row;
      cmd.col_sel    = col;
      cmd.attr_in    = 8'($urandom);
      cmd.lines_back = 7'($urandom);
      return cmd;
   endfunction

   task automatic queue_cmd(logic [2:0] mode, logic [7:0] ch, logic [4:0] row,
                            logic [6:0] col);
      pending_cmds.push_back(make_cmd(mode, ch, row, col));
   endtask

   task automatic queue_random(int count);
      req_type cmd;
      int      pick;
      for (int n = 0; n < count; n++) begin
         cmd  = make_cmd(3'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
         pick = $urandom_range(99);
         if (pick < 40) begin
            cmd.mode = MODE_PUT;
            case ($urandom_range(9))
               0, 1: cmd.char_code = CH_NEWLINE;
               2:    cmd.char_code = CH_BACKSPACE;
               default: ;
            endcase
         end else if (pick < 50) begin
            // jump to the bottom row and feed a line: the scroll path
            queue_cmd(MODE_SET_CUR, 8'($urandom), 5'(ROWS-1), 7'($urandom_range(COLUMNS-1)));
            cmd.mode      = MODE_PUT;
            cmd.char_code = CH_NEWLINE;
         end else if (pick < 57) cmd.mode = MODE_SET_CUR;
         else if (pick < 62) cmd.mode = MODE_SET_COLOR;
         else if (pick < 63) cmd.mode = MODE_CLEAR;
         else if (pick < 72) cmd.mode = MODE_WRITE;
         else if (pick < 84) cmd.mode = MODE_READ;
         else if (pick < 97) begin
            cmd.mode = MODE_HIST;
            if ($urandom_range(3) != 0) begin
               cmd.lines_back = 7'($urandom_range(ring_fill > 0 ? 127 : 0));
               cmd.col_sel    = 7'($urandom_range(COLUMNS-1));
            end
         end else cmd.mode = MODE_NOP;
         // keep most positions on screen so that writes and reads land
         if (cmd.mode inside {MODE_WRITE, MODE_READ} && $urandom_range(4) != 0) begin
            cmd.row_sel = 5'($urandom_range(ROWS-1));
            cmd.col_sel = 7'($urandom_range(COLUMNS-1));
         end
         pending_cmds.push_back(cmd);
      end
   endtask

   // ---------------------------------------------------------------------
   // register writes, made while the block is idle or, once, during the reset blanking pass
   // ---------------------------------------------------------------------
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SCROLL_ENABLE) scroll_on = value[0];
      else if (idx == CSR_DEFAULT_COLOR) color_default = value;
      csr_valid <= 1'b0;
   endtask

   // hold the sender back until every transaction is answered
   task automatic drain();
      while (pending_cmds.size() != 0 || req_valid || expected_status.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      send_idle_pct = 38;
      recv_idle_pct = 71;
      hold_ticket   = 0;
      mismatches    = 0;
      scroll_on     = 1'b1;
      color_default = RESET_COLOR;
      attr_now      = RESET_COLOR;
      ring_head     = 0;
      ring_fill     = 0;
      row_now       = 0;
      col_now       = 0;
      mirror_blank();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // an index past the register list must change nothing
      csr_write(CSR_UNUSED, 8'hFF);
      while (req_stall) @(posedge clock);

      // directed: backspace at home first, then field extremes and edge cases
      queue_cmd(MODE_PUT, CH_BACKSPACE, 5'd0, 7'd0);
      queue_cmd(MODE_PUT, 8'h41, 5'd0, 7'd0);
      queue_cmd(MODE_PUT, 8'hFF, 5'd0, 7'd0);
      queue_cmd(MODE_PUT, 8'h00, 5'd0, 7'd0);
      queue_cmd(MODE_PUT, CH_NEWLINE, 5'd0, 7'd0);
      queue_cmd(MODE_PUT, CH_BACKSPACE, 5'd0, 7'd0);
      queue_cmd(MODE_SET_CUR, 8'h00, 5'd31, 7'd127);
      queue_cmd(MODE_SET_COLOR, 8'h00, 5'd0, 7'd0);
      pending_cmds[$].attr_in = 8'hFF;
      queue_cmd(MODE_WRITE, 8'hFF, 5'd24, 7'd79);
      queue_cmd(MODE_WRITE, 8'h55, 5'd25, 7'd0);
      queue_cmd(MODE_READ, 8'h00, 5'd24, 7'd79);
      queue_cmd(MODE_READ, 8'h00, 5'd0, 7'd80);
      queue_cmd(MODE_HIST, 8'h00, 5'd0, 7'd0);
      pending_cmds[$].lines_back = 7'd0;
      queue_cmd(MODE_SET_CUR, 8'h00, 5'd24, 7'd79);
      queue_cmd(MODE_PUT, 8'h7E, 5'd0, 7'd0);
      queue_cmd(MODE_HIST, 8'h00, 5'd0, 7'd0);
      pending_cmds[$].lines_back = 7'd0;
      queue_cmd(MODE_HIST, 8'h00, 5'd0, 7'd80);
      pending_cmds[$].lines_back = 7'd0;
      queue_cmd(MODE_NOP, 8'hFF, 5'd31, 7'd127);
      queue_cmd(MODE_SET_CUR, 8'h00, 5'd24, 7'd0);
      queue_cmd(MODE_PUT, CH_NEWLINE, 5'd0, 7'd0);
      queue_cmd(MODE_HIST, 8'h00, 5'd0, 7'd0);
      pending_cmds[$].lines_back = 7'd1;
      queue_cmd(MODE_CLEAR, 8'h00, 5'd0, 7'd0);
      queue_cmd(MODE_READ, 8'h00, 5'd0, 7'd0);
      drain();
      queue_random(450);
      drain();

      // wrap mode, brightest default color, idling swapped
      csr_write(CSR_SCROLL_ENABLE, 8'h00);
      csr_write(CSR_DEFAULT_COLOR, 8'hFF);
      send_idle_pct = 71;
      recv_idle_pct = 38;
      queue_cmd(MODE_SET_CUR, 8'h00, 5'd24, 7'd5);
      queue_cmd(MODE_PUT, CH_NEWLINE, 5'd0, 7'd0);
      queue_cmd(MODE_CLEAR, 8'h00, 5'd0, 7'd0);
      queue_random(450);
      drain();

      // scrolling again with color zero, no idling; pause halfway
      csr_write(CSR_SCROLL_ENABLE, 8'h01);
      csr_write(CSR_DEFAULT_COLOR, 8'h00);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(250);
      drain();
      queue_random(250);
      drain();

      // long receiver hold while the sender keeps offering
      csr_write(CSR_DEFAULT_COLOR, 8'($urandom));
      hold_ticket++;
      queue_random(300);
      drain();

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // driver: present pending commands, mirror each accepted transaction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type status;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            mirror_apply(req_data, status);
            expected_status.push_back(status);
         end
         // hold a stalled payload; otherwise offer the next one or idle
         if (!req_valid || !req_stall) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_cmds.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stall plus one long hold per ticket
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_seen <= 0;
         hold_left <= 0;
      end else if (hold_seen != hold_ticket) begin
         hold_seen <= hold_ticket;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < recv_idle_pct;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: compare each accepted result with the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, rsp_data);
            mismatches++;
         end else begin
            want = expected_status.pop_front();
            if (rsp_data.cursor_row !== want.cursor_row) begin
               $display("%0t: cursor_row expected %0d actual %0d", $realtime,
                        want.cursor_row, rsp_data.cursor_row);
               mismatches++;
            end
            if (rsp_data.cursor_col !== want.cursor_col) begin
               $display("%0t: cursor_col expected %0d actual %0d", $realtime,
                        want.cursor_col, rsp_data.cursor_col);
               mismatches++;
            end
            if (rsp_data.cursor_linear !== want.cursor_linear) begin
               $display("%0t: cursor_linear expected %0d actual %0d", $realtime,
                        want.cursor_linear, rsp_data.cursor_linear);
               mismatches++;
            end
            if (rsp_data.read_char !== want.read_char) begin
               $display("%0t: read_char expected %h actual %h", $realtime,
                        want.read_char, rsp_data.read_char);
               mismatches++;
            end
            if (rsp_data.read_attr !== want.read_attr) begin
               $display("%0t: read_attr expected %h actual %h", $realtime,
                        want.read_attr, rsp_data.read_attr);
               mismatches++;
            end
            if (rsp_data.read_valid !== want.read_valid) begin
               $display("%0t: read_valid expected %b actual %b", $realtime,
                        want.read_valid, rsp_data.read_valid);
               mismatches++;
            end
            if (rsp_data.history_count !== want.history_count) begin
               $display("%0t: history_count expected %0d actual %0d", $realtime,
                        want.history_count, rsp_data.history_count);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: end the run when no transaction moves for too long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

[text_terminal_writer_top.f]
+incdir+design
design/ttw_pkg.sv
design/ttw_ram.sv
design/ttw_ctrl.sv
design/ttw_dp.sv
design/text_terminal_writer_top.sv
design/ttw_checker.sv
test/text_terminal_writer_top_test.sv
